>>> design/wildcard_name_matcher_core_defines.svh
// assertion macros for the wildcard name matcher core
// used by files that carry concurrent checks; expects i_clk and i_rst_n in scope
`ifndef WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WNM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wnm check failed");

// next-cycle implication, disabled during reset
`define WNM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wnm check failed");

`endif

>>> design/wnm_pkg.sv
// shared constants and types for the wildcard name matcher
// no dependencies
`timescale 1ns / 1ps

package wnm_pkg;

    localparam int REG_BYTES       = 16;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;

    localparam logic [7:0] WILD_ONE = 8'h3F;
    localparam logic [7:0] WILD_ANY = 8'h2A;

    localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;
    localparam logic [1:0] REG_FILTER_EN    = 2'd3;

    typedef struct packed {
        logic [REG_BYTES*8-1:0] pattern;
        logic [LEN_W-1:0]       len;
        logic                   filter_en;
    } t_cfg;

endpackage

>>> design/wnm_step.sv
// live-position update for the wildcard name matcher: star closure and byte step
// depends on wnm_pkg
`timescale 1ns / 1ps

module wnm_step #(
    parameter int MAX_PATTERN = wnm_pkg::MAX_PATTERN_DEF
) (
    input  wnm_pkg::t_cfg i_cfg,
    input  logic [((MAX_PATTERN < wnm_pkg::REG_BYTES) ? MAX_PATTERN
                   : wnm_pkg::REG_BYTES):0] i_base,
    input  logic [7:0]    i_name_char,
    output logic [((MAX_PATTERN < wnm_pkg::REG_BYTES) ? MAX_PATTERN
                   : wnm_pkg::REG_BYTES):0] o_next_base,
    output logic          o_hit
);

    localparam int NPOS   = (MAX_PATTERN < wnm_pkg::REG_BYTES) ? MAX_PATTERN
                            : wnm_pkg::REG_BYTES;
    localparam int W      = NPOS + 1;
    localparam int IW     = $clog2(W);
    localparam int ROUNDS = $clog2(W);

    logic [wnm_pkg::LEN_W-1:0] eff_len;
    logic [NPOS-1:0]           in_use;
    logic [NPOS-1:0]           star;
    logic [NPOS-1:0]           adv;
    logic [W-1:0]              prop;
    logic [W-1:0]              live;

    // prefix propagation of live bits across runs of '*'
    function automatic logic [W-1:0] close_stars(input logic [W-1:0] g_in,
                                                 input logic [W-1:0] p_in);
        logic [W-1:0] g;
        logic [W-1:0] p;
        g = g_in;
        p = p_in;
        for (int k = 0; k < ROUNDS; k++) begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        return g;
    endfunction

    always_comb begin
        if (i_cfg.len > wnm_pkg::LEN_W'(NPOS)) begin
            eff_len = wnm_pkg::LEN_W'(NPOS);
        end else begin
            eff_len = i_cfg.len;
        end
    end

    always_comb begin
        for (int p = 0; p < NPOS; p++) begin
            in_use[p] = (wnm_pkg::LEN_W'(p) < eff_len);
            star[p]   = in_use[p] && (i_cfg.pattern[8*p +: 8] == wnm_pkg::WILD_ANY);
            adv[p]    = in_use[p] && !star[p]
                        && ((i_cfg.pattern[8*p +: 8] == wnm_pkg::WILD_ONE)
                            || (i_cfg.pattern[8*p +: 8] == i_name_char));
        end
    end

    assign prop = {star, 1'b0};
    assign live = close_stars(i_base, prop);

    always_comb begin
        o_next_base = '0;
        for (int p = 0; p < NPOS; p++) begin
            if (live[p] && star[p]) begin
                o_next_base[p] = 1'b1;
            end
            if (live[p] && adv[p]) begin
                o_next_base[p+1] = 1'b1;
            end
        end
    end

    assign o_hit = live[eff_len[IW-1:0]];

endmodule

>>> design/wildcard_name_matcher_core.sv
// top level of the wildcard name matcher: apb register file, live-position state,
// two-entry result buffer; depends on wnm_pkg, wnm_step and the defines header
`timescale 1ns / 1ps
`include "wildcard_name_matcher_core_defines.svh"

// Streams a name one byte per transaction (i_name_end low) and compares it against a
// glob pattern of up to 16 bytes held in registers: '?' takes any one byte, '*' any
// run of bytes. A transaction with i_name_end high closes the name, returns one
// result transaction carrying o_match (forced high while filter_en is clear) and
// rearms for the next name; byte transactions return nothing. While o_ready is high
// the next transaction may follow in the next cycle: the live-position set lives in
// one register that is updated by a single pass of compare and star-closure logic,
// and each result is registered into the buffer that drives o_valid. A two-entry
// result buffer keeps input flowing while the output side stalls; o_ready drops
// only when both entries are full. Any register write rearms the matcher; write
// registers only while no name is in progress.
module wildcard_name_matcher_core #(
    parameter int MAX_PATTERN = wnm_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_name_char,
    input  logic                           i_name_end,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_match,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wnm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wnm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wnm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int NPOS = (MAX_PATTERN < wnm_pkg::REG_BYTES) ? MAX_PATTERN
                          : wnm_pkg::REG_BYTES;
    localparam int W    = NPOS + 1;
    localparam logic [W-1:0] LIVE_ARM = W'(1);

    wnm_pkg::t_cfg r_cfg;
    wnm_pkg::t_cfg n_cfg;
    logic [W-1:0]  r_base;
    logic [W-1:0]  n_base;
    logic [W-1:0]  step_base;
    logic          step_hit;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          r_out_match;
    logic          n_out_match;
    logic          r_skid_valid;
    logic          n_skid_valid;
    logic          r_skid_match;
    logic          n_skid_match;

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          in_acc;
    logic          out_take;
    logic          res_push;
    logic          res_bit;
    logic          unf_push;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:3];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;
    assign res_push = in_acc && i_name_end;
    assign res_bit  = !r_cfg.filter_en || step_hit;
    assign unf_push = res_push && !r_cfg.filter_en && !r_out_valid;

    wnm_step #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_base      (r_base),
        .i_name_char (i_name_char),
        .o_next_base (step_base),
        .o_hit       (step_hit)
    );

    // register file
    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (cfg_idx)
                wnm_pkg::REG_PATTERN_LOW: begin
                    n_cfg.pattern[63:0] = pwdata;
                end
                wnm_pkg::REG_PATTERN_HIGH: begin
                    n_cfg.pattern[127:64] = pwdata;
                end
                wnm_pkg::REG_PATTERN_LEN: begin
                    n_cfg.len = pwdata[wnm_pkg::LEN_W-1:0];
                end
                wnm_pkg::REG_FILTER_EN: begin
                    n_cfg.filter_en = pwdata[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            wnm_pkg::REG_PATTERN_LOW:  prdata = r_cfg.pattern[63:0];
            wnm_pkg::REG_PATTERN_HIGH: prdata = r_cfg.pattern[127:64];
            wnm_pkg::REG_PATTERN_LEN:
                prdata = {{(wnm_pkg::CFG_DATA_W-wnm_pkg::LEN_W){1'b0}}, r_cfg.len};
            wnm_pkg::REG_FILTER_EN:
                prdata = {{(wnm_pkg::CFG_DATA_W-1){1'b0}}, r_cfg.filter_en};
            default:                   prdata = '0;
        endcase
    end

    // live-position state, rearmed on end of name or any register write
    always_comb begin
        n_base = r_base;
        if (cfg_wr) begin
            n_base = LIVE_ARM;
        end else if (in_acc) begin
            n_base = i_name_end ? LIVE_ARM : step_base;
        end
    end

    // two-entry result buffer
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_match  = r_out_match;
        n_skid_valid = r_skid_valid;
        n_skid_match = r_skid_match;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out_match  = r_skid_match;
                n_skid_valid = 1'b0;
            end
        end else if (res_push) begin
            if (!r_out_valid || out_take) begin
                n_out_valid = 1'b1;
                n_out_match = res_bit;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_match = res_bit;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_base       <= LIVE_ARM;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_cfg        <= n_cfg;
            r_base       <= n_base;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_match  <= n_out_match;
        r_skid_match <= n_skid_match;
    end

    assign o_valid = r_out_valid;
    assign o_match = r_out_match;

    `WNM_ASSERT_IMPL(a_skid_needs_out, r_skid_valid, r_out_valid)
    `WNM_ASSERT_NEXT(a_cfg_rearms, cfg_wr, r_base == LIVE_ARM)
    `WNM_ASSERT_NEXT(a_end_rearms, res_push && !cfg_wr, r_base == LIVE_ARM)
    `WNM_ASSERT_NEXT(a_unfiltered_match, unf_push, r_out_valid && r_out_match)

endmodule
